/* hdl/wxp_pkg.sv */
// Package for the wide three-row permutation round unit: lane types, mode codes,
// datapath command struct and the round step functions.
// No dependencies.
`default_nettype none

package wxp_pkg;

  localparam int unsigned LANE_W   = 64;
  localparam int unsigned NUM_COLS = 8;
  localparam int unsigned NUM_ROWS = 3;
  localparam int unsigned NUM_LANES = NUM_COLS * NUM_ROWS;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned MASK_W   = LANE_W / 8;

  localparam int unsigned THETA_ROT_A = 20;
  localparam int unsigned THETA_ROT_B = 56;
  localparam int unsigned RHO_ROT_R1  = 3;
  localparam int unsigned RHO_SHIFT_R1 = 3;
  localparam int unsigned RHO_SHIFT_R2 = 5;

  typedef logic [LANE_W-1:0] lane_t;
  typedef logic [NUM_LANES-1:0][LANE_W-1:0] state_t;

  typedef enum logic [1:0] {
    MODE_XOR   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_ROUND = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  // Controller to datapath: execute the accepted beat this cycle.
  typedef struct packed {
    logic exec;
  } cmd_t;

  function automatic lane_t rotl(input lane_t v, input int unsigned n);
    rotl = (v << n) | (v >> (LANE_W - n));
  endfunction

  function automatic lane_t byte_mask_expand(input logic [MASK_W-1:0] bm);
    lane_t m;
    for (int i = 0; i < MASK_W; i++) begin
      m[8*i +: 8] = {8{bm[i]}};
    end
    return m;
  endfunction

  function automatic state_t chi(input state_t s);
    state_t t;
    lane_t a, b, c;
    t = s;
    for (int x = 0; x < NUM_COLS; x++) begin
      a = s[x];
      b = s[NUM_COLS + x];
      c = s[2*NUM_COLS + x];
      a = a ^ (~b & c);
      b = b ^ (~c & a);
      c = c ^ (~a & b);
      t[x] = a;
      t[NUM_COLS + x] = b;
      t[2*NUM_COLS + x] = c;
    end
    return t;
  endfunction

  function automatic state_t rho(input state_t s);
    state_t t;
    t = s;
    for (int x = 0; x < NUM_COLS; x++) begin
      t[2*NUM_COLS + x] = s[2*NUM_COLS + ((x + NUM_COLS - RHO_SHIFT_R2) % NUM_COLS)];
      t[NUM_COLS + x]   = rotl(s[NUM_COLS + ((x + NUM_COLS - RHO_SHIFT_R1) % NUM_COLS)],
                               RHO_ROT_R1);
    end
    return t;
  endfunction

  function automatic state_t theta(input state_t s);
    state_t t;
    lane_t par [NUM_COLS];
    lane_t p, e;
    t = s;
    for (int x = 0; x < NUM_COLS; x++) begin
      par[x] = s[x] ^ s[NUM_COLS + x] ^ s[2*NUM_COLS + x];
    end
    for (int x = 0; x < NUM_COLS; x++) begin
      p = par[(x + NUM_COLS - 1) % NUM_COLS];
      e = rotl(p, THETA_ROT_A) ^ rotl(p, THETA_ROT_B);
      t[x] = s[x] ^ e;
      t[NUM_COLS + x] = s[NUM_COLS + x] ^ e;
      t[2*NUM_COLS + x] = s[2*NUM_COLS + x] ^ e;
    end
    return t;
  endfunction

  function automatic state_t perm_round(input state_t s, input lane_t rc);
    state_t t;
    t = s;
    t[0] = s[0] ^ rc;
    t = chi(t);
    t = rho(t);
    t = theta(t);
    t = rho(t);
    return t;
  endfunction

endpackage

`default_nettype wire

/* hdl/wide_xoodoo_like_permutation_round_unit.sv */
// Top level of the wide three-row permutation round unit (24 lanes x 64 bits).
// Instantiates wxp_ctrl and wxp_dp; depends on wxp_pkg.
`default_nettype none

// Channel | Handshake            | Payload
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_stall  | mode, lane_index, lane_data, byte_mask, round_const
// out     | out_valid / out_stall| read_data
//
// Cycles: every beat, including a full round, executes in the cycle it is
//   accepted; one beat per cycle sustained while out_stall stays low. The round
//   (iota, chi, rho, theta, rho) is combinational logic between the lane
//   registers and completes in the cycle the beat is accepted.
// Results: one result beat per input beat, registered, valid the next cycle.
// Stalls: a new input beat is taken while a result waits, unless out_stall is
//   high; then in_stall rises and the result register holds.
// Reset: rst clears all lanes to zero and clears out_valid; read_data is not reset.
module wide_xoodoo_like_permutation_round_unit
  import wxp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        mode,
  input  wire logic [IDX_W-1:0]  lane_index,
  input  wire lane_t             lane_data,
  input  wire logic [MASK_W-1:0] byte_mask,
  input  wire lane_t             round_const,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lane_t                  read_data
);

  // Execute command from controller to datapath.
  cmd_t cmd;

  // Controller: drive in_stall and out_valid, fire the datapath on accept.
  wxp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: update lanes and load the result register on each executed beat.
  wxp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .lane_index  (lane_index),
    .lane_data   (lane_data),
    .byte_mask   (byte_mask),
    .round_const (round_const),
    .read_data   (read_data)
  );

endmodule

`default_nettype wire

/* hdl/wxp_ctrl.sv */
// Handshake controller for the permutation round unit: owns the output register
// state and issues the execute command. Depends on wxp_pkg.
`default_nettype none

module wxp_ctrl
  import wxp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output cmd_t      cmd
);

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  state_t state;

  // Hold input while a result waits and the sink stalls.
  assign in_stall  = (state == ST_FULL) && out_stall;
  assign cmd.exec  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_EMPTY;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_EMPTY: begin
          if (cmd.exec) begin
            state     <= ST_FULL;
            out_valid <= 1'b1;
          end
        end
        ST_FULL: begin
          if (!out_stall && !cmd.exec) begin
            state     <= ST_EMPTY;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state     <= ST_EMPTY;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  a_exec_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("executed beat did not produce a result");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !in_valid |=> !out_valid)
    else $error("result repeated after drain");

endmodule

`default_nettype wire

/* hdl/wxp_dp.sv */
// Datapath of the permutation round unit: 24-lane state, lane XOR/read and
// combinational round logic, plus the result register. Depends on wxp_pkg.
`default_nettype none

module wxp_dp
  import wxp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic [1:0]        mode,
  input  wire logic [IDX_W-1:0]  lane_index,
  input  wire lane_t             lane_data,
  input  wire logic [MASK_W-1:0] byte_mask,
  input  wire lane_t             round_const,
  output lane_t                  read_data
);

  state_t lanes;
  state_t lanes_next;
  lane_t  result_next;
  logic   idx_ok;
  mode_t  op;

  assign idx_ok = ({1'b0, lane_index} < (IDX_W+1)'(NUM_LANES));
  assign op     = mode_t'(mode);

  always_comb begin
    lanes_next  = lanes;
    result_next = '0;
    case (op)
      MODE_XOR: begin
        if (idx_ok) begin
          lanes_next[lane_index] = lanes[lane_index] ^ (lane_data & byte_mask_expand(byte_mask));
        end
      end
      MODE_READ: begin
        if (idx_ok) begin
          result_next = lanes[lane_index];
        end
      end
      MODE_ROUND: begin
        lanes_next = perm_round(lanes, round_const);
      end
      default: begin
        lanes_next = lanes;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes <= '0;
    end else if (cmd.exec) begin
      lanes <= lanes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_data <= result_next;
    end
  end

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (op != MODE_READ) |=> read_data == '0)
    else $error("nonzero result for a non-read beat");

  a_read_no_change: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (op == MODE_READ || op == MODE_NOP) |=> $stable(lanes))
    else $error("state changed on a read or no-op beat");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(lanes))
    else $error("state changed without a beat");

endmodule

`default_nettype wire
